// ===== design/wzhd_pkg.sv =====
// Shared types and constants of the window stacking, hit test and drag unit.
package wzhd_pkg;

   localparam int unsigned RAW_MAX = 32767;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_MOUSE = 2'd1,
      CMD_MOVE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADH    = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'd0,
      CSR_HEIGHT = 1'd1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_HIT,
      S_GRAB,
      S_DONE
   } state_type;

   // Rectangle of one window slot.
   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [11:0] width;
      logic [11:0] height;
   } rect_type;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic        hit_en;     // evaluate containment
      logic [11:0] cx;
      logic [11:0] cy;
   } cell_ctl_type;

endpackage

// ===== design/wzhd_cell.sv =====
// One stack position: holds the slot number at that position and tests the cursor on it.
module wzhd_cell #(
   parameter int SW = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wzhd_pkg::cell_ctl_type ctl,
   input  logic                  in_range,     // position below window count
   input  logic                  shift_sel,    // this position takes its upper neighbour
   input  logic                  add_sel,      // this position takes the new slot
   input  logic [SW-1:0]         above_slot,
   input  logic [SW-1:0]         add_slot,
   input  wzhd_pkg::rect_type    rect,         // rectangle of the slot held here
   output logic [SW-1:0]         slot,
   output logic                  hit
);
   import wzhd_pkg::*;

   logic [SW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in;
   logic signed [17:0] l, t, r, b, x, y;

   always_comb begin
      slot_in = slot_ff;
      if (add_sel) begin
         slot_in = add_slot;
      end else if (shift_sel) begin
         slot_in = above_slot;
      end
      l = 18'(signed'(rect.left));
      t = 18'(signed'(rect.top));
      r = l + 18'(rect.width);
      b = t + 18'(rect.height);
      x = 18'(ctl.cx);
      y = 18'(ctl.cy);
      hit_in = hit_ff;
      if (ctl.hit_en) begin
         hit_in = in_range && x >= l && x < r && y >= t && y < b;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign slot = slot_ff;
   assign hit  = hit_ff;
endmodule

// ===== design/window_zorder_hit_drag_unit.sv =====
// Top level of the window stacking, hit test and drag unit.
//  channel | direction | handshake
//  req_    | in        | req_valid / req_ready
//  rsp_    | out       | rsp_valid / rsp_ready
//  csr_    | in        | csr_we, no stall
// One request at a time: add, move and unused commands pass the scale and done states,
// a mouse event the scale multiply, reciprocal divide, cell hit test, raise/grab/drag
// and done steps; the next request is taken once the answer is registered and the state
// is back in idle. Reset is synchronous and clears control state only.
// A stalled response holds in its output register; the next request runs and
// waits in its final state until that register frees.
module window_zorder_hit_drag_unit #(
   parameter int MAX_WINDOWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [11:0] req_size_w,
   input  logic [11:0] req_size_h,
   input  logic [3:0]  req_handle,
   input  logic [14:0] req_raw_x,
   input  logic [14:0] req_raw_y,
   input  logic        req_left_pressed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_new_handle,
   output logic        rsp_top_valid,
   output logic [3:0]  rsp_top_handle,
   output logic [11:0] rsp_cursor_x,
   output logic [11:0] rsp_cursor_y,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import wzhd_pkg::*;

   localparam int N  = MAX_WINDOWS;
   localparam int SW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N + 1);

   state_type state_ff, state_in;
   logic [11:0] scr_w_ff, scr_h_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [11:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic prev_ff, prev_in, grab_ff, grab_in;
   logic [SW-1:0] gslot_ff, gslot_in;
   logic [1:0] cmd_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [11:0] w_ff, h_ff;
   logic [3:0] hd_ff;
   logic [14:0] rx_ff, ry_ff;
   logic left_ff;
   logic [26:0] mx_ff, mx_in, my_ff, my_in;
   logic [11:0] nx_ff, nx_in, ny_ff, ny_in;
   logic hfound_ff, hfound_in;
   logic rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic [3:0] nh_ff, nh_in;
   logic [1:0] rsp_st_ff, rsp_st_in;
   logic [3:0] rsp_nh_ff, rsp_nh_in;
   logic rsp_tv_ff, rsp_tv_in;
   logic [3:0] rsp_th_ff, rsp_th_in;
   logic [11:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;

   rect_type rect_ff [N];
   logic rect_we;
   logic [SW-1:0] rect_wa;
   rect_type rect_wd;

   cell_ctl_type ctl;
   logic [SW-1:0] slot_w [N];
   logic hit_w [N];
   logic [N-1:0] shift_sel, add_sel, hits;
   logic [SW-1:0] add_slot_w;
   logic found;
   logic [SW-1:0] hit_p, hit_s, top_w;

   // divide by 32767: q = (m + (m>>15) + 1) >> 15 exact for m < 2^27
   function automatic logic [11:0] div_raw(input logic [26:0] m);
      logic [27:0] s;
      s = 28'(m) + 28'(m >> 15) + 28'd1;
      return 12'(s >> 15);
   endfunction

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [SW-1:0] above;
      if (i == N - 1) begin : g_top
         assign above = slot_w[i];
      end else begin : g_mid
         assign above = slot_w[i+1];
      end
      wzhd_cell #(.SW(SW)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .in_range(CW'(i) < count_ff),
         .shift_sel(shift_sel[i]), .add_sel(add_sel[i]),
         .above_slot(above), .add_slot(add_slot_w),
         .rect(rect_ff[slot_w[i]]),
         .slot(slot_w[i]), .hit(hit_w[i])
      );
      assign hits[i] = hit_w[i];
   end

   always_comb begin
      found = 1'b0;
      hit_p = '0;
      for (int i = 0; i < N; i++) begin
         if (hits[i]) begin
            found = 1'b1;
            hit_p = SW'(i);
         end
      end
      hit_s = slot_w[hit_p];
   end

   assign top_w = slot_w[SW'(count_ff - CW'(1))];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      prev_in = prev_ff;
      grab_in = grab_ff;
      gslot_in = gslot_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      hfound_in = hfound_ff;
      rv_in = rv_ff;
      st_in = st_ff;
      nh_in = nh_ff;
      rsp_st_in = rsp_st_ff;
      rsp_nh_in = rsp_nh_ff;
      rsp_tv_in = rsp_tv_ff;
      rsp_th_in = rsp_th_ff;
      rsp_cx_in = rsp_cx_ff;
      rsp_cy_in = rsp_cy_ff;
      rect_we = 1'b0;
      rect_wa = '0;
      rect_wd = '0;
      ctl = '0;
      ctl.cx = nx_ff;
      ctl.cy = ny_ff;
      shift_sel = '0;
      add_sel = '0;
      add_slot_w = SW'(count_ff);
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            st_in = ST_OK;
            nh_in = '0;
            mx_in = 27'(scr_w_ff) * 27'(rx_ff);
            my_in = 27'(scr_h_ff) * 27'(ry_ff);
            case (cmd_type'(cmd_ff))
               CMD_ADD: begin
                  if (count_ff >= CW'(N)) begin
                     st_in = ST_FULL;
                  end else begin
                     rect_we = 1'b1;
                     rect_wa = SW'(count_ff);
                     rect_wd = '{px_ff, py_ff, w_ff, h_ff};
                     for (int i = 0; i < N; i++) begin
                        add_sel[i] = (CW'(i) == count_ff);
                     end
                     count_in = count_ff + CW'(1);
                     nh_in = 4'(count_ff);
                  end
                  state_in = S_DONE;
               end
               CMD_MOVE: begin
                  if (32'(hd_ff) >= 32'(count_ff) || 32'(hd_ff) >= 32'(N)) begin
                     st_in = ST_BADH;
                  end else begin
                     rect_we = 1'b1;
                     rect_wa = SW'(hd_ff);
                     rect_wd = rect_ff[SW'(hd_ff)];
                     rect_wd.left = px_ff;
                     rect_wd.top = py_ff;
                  end
                  state_in = S_DONE;
               end
               CMD_MOUSE: state_in = S_HIT;
               default: state_in = S_DONE;
            endcase
         end
         S_HIT: begin
            nx_in = div_raw(mx_ff);
            ny_in = div_raw(my_ff);
            state_in = S_GRAB;
         end
         S_GRAB: begin
            ctl.hit_en = 1'b1;
            hfound_in = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd_ff == CMD_MOUSE && !hfound_ff) begin
               // raise the topmost hit, grab and drag
               hfound_in = 1'b1;
               if (left_ff && !prev_ff && found) begin
                  add_slot_w = hit_s;
                  for (int i = 0; i < N; i++) begin
                     shift_sel[i] = (SW'(i) >= hit_p) && (CW'(i) + CW'(1) < count_ff);
                     add_sel[i] = (CW'(i) + CW'(1) == count_ff);
                  end
               end
               if (left_ff) begin
                  if (!grab_ff && found) begin
                     grab_in = 1'b1;
                     gslot_in = hit_s;
                  end
                  if (grab_ff || found) begin
                     rect_we = 1'b1;
                     rect_wa = grab_ff ? gslot_ff : hit_s;
                     rect_wd = rect_ff[rect_wa];
                     rect_wd.left = rect_wd.left + 16'(nx_ff) - 16'(cur_x_ff);
                     rect_wd.top = rect_wd.top + 16'(ny_ff) - 16'(cur_y_ff);
                  end
               end else begin
                  grab_in = 1'b0;
                  gslot_in = '0;
               end
               cur_x_in = nx_ff;
               cur_y_in = ny_ff;
               prev_in = left_ff;
            end else if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rsp_st_in = st_ff;
               rsp_nh_in = nh_ff;
               rsp_tv_in = count_ff != '0;
               rsp_th_in = (count_ff != '0) ? 4'(top_w) : 4'd0;
               rsp_cx_in = cur_x_ff;
               rsp_cy_in = cur_y_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         w_ff <= req_size_w;
         h_ff <= req_size_h;
         hd_ff <= req_handle;
         rx_ff <= req_raw_x;
         ry_ff <= req_raw_y;
         left_ff <= req_left_pressed;
      end
      mx_ff <= mx_in;
      my_ff <= my_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      st_ff <= st_in;
      nh_ff <= nh_in;
      rsp_st_ff <= rsp_st_in;
      rsp_nh_ff <= rsp_nh_in;
      rsp_tv_ff <= rsp_tv_in;
      rsp_th_ff <= rsp_th_in;
      rsp_cx_ff <= rsp_cx_in;
      rsp_cy_ff <= rsp_cy_in;
      if (rect_we) begin
         rect_ff[rect_wa] <= rect_wd;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         scr_w_ff <= 12'd1024;
         scr_h_ff <= 12'd768;
         count_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         prev_ff <= 1'b0;
         grab_ff <= 1'b0;
         gslot_ff <= '0;
         hfound_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         prev_ff <= prev_in;
         grab_ff <= grab_in;
         gslot_ff <= gslot_in;
         hfound_ff <= hfound_in;
         rv_ff <= rv_in;
         if (csr_we && csr_index == CSR_WIDTH) begin
            scr_w_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_HEIGHT) begin
            scr_h_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_new_handle = rsp_nh_ff;
   assign rsp_top_valid = rsp_tv_ff;
   assign rsp_top_handle = rsp_th_ff;
   assign rsp_cursor_x = rsp_cx_ff;
   assign rsp_cursor_y = rsp_cy_ff;

   property p_count_max;
      @(posedge clock) disable iff (reset) count_ff <= CW'(N);
   endproperty
   a_count_max: assert property (p_count_max) else $error("window count overflow");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rv_ff && !rsp_ready |=> rv_ff && $stable({rsp_st_ff, rsp_nh_ff, rsp_tv_ff,
                                                   rsp_th_ff, rsp_cx_ff, rsp_cy_ff});
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled response changed");

   property p_grab_slot;
      @(posedge clock) disable iff (reset) grab_ff |-> CW'(gslot_ff) < count_ff;
   endproperty
   a_grab_slot: assert property (p_grab_slot) else $error("grab of absent window");
endmodule

// ===== test/tb_window_zorder_hit_drag_unit.sv =====
// Self-checking testbench of the window stacking, hit test and drag unit.
module tb_window_zorder_hit_drag_unit;
   import wzhd_pkg::*;

   localparam int N_WIN       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [3:0]         hd;
      logic [14:0]        rx;
      logic [14:0]        ry;
      logic               lp;
   } req_item;

   typedef struct packed {
      status_type  st;
      logic [3:0]  nh;
      logic        tv;
      logic [3:0]  th;
      logic [11:0] cx;
      logic [11:0] cy;
   } rsp_item;

   typedef struct packed {
      logic    typed;
      rsp_item r;
   } typed_rsp;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [11:0] req_size_w = '0;
   logic [11:0] req_size_h = '0;
   logic [3:0]  req_handle = '0;
   logic [14:0] req_raw_x = '0;
   logic [14:0] req_raw_y = '0;
   logic        req_left_pressed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_new_handle;
   logic        rsp_top_valid;
   logic [3:0]  rsp_top_handle;
   logic [11:0] rsp_cursor_x;
   logic [11:0] rsp_cursor_y;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   window_zorder_hit_drag_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted block state
   logic [15:0] win_x [N_WIN];
   logic [15:0] win_y [N_WIN];
   logic [11:0] win_w [N_WIN];
   logic [11:0] win_h [N_WIN];
   logic [3:0]  z_order [N_WIN];
   int unsigned win_count = 0;
   int unsigned cur_x = 0, cur_y = 0;
   logic        was_left = 1'b0, dragging = 1'b0;
   logic [3:0]  drag_slot = '0;
   int unsigned scr_w = 1024, scr_h = 768;

   rsp_item     pending_rsp [$];
   int          errors = 0;
   int unsigned cycles = 0;
   int          n_acc = 0;
   logic        long_hold = 1'b0;
   logic        quiet = 1'b0;

   req_item  dir_req [] = '{
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_MOVE, 16'sd5, 16'sd5, 12'd1, 12'd1, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_NONE, -16'sd1, -16'sd1, 12'hFFF, 12'hFFF, 4'hF, 15'h7FFF, 15'h7FFF, 1'b1},
      '{CMD_ADD, -16'sd32768, -16'sd32768, 12'd4095, 12'd4095, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_ADD, 16'sd32767, 16'sd32767, 12'd1, 12'd1, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_ADD, 16'sd0, 16'sd0, 12'd200, 12'd100, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'h7FFF, 15'h7FFF, 1'b0},
      '{CMD_ADD, 16'sd100, 16'sd50, 12'd300, 12'd300, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd1600, 15'd2133, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd3200, 15'd4266, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd100, 15'd90, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd100, 15'd90, 1'b0},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd9600, 15'd9000, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd6400, 15'd6400, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd6400, 15'd6400, 1'b0},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd30000, 15'd30000, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd3200, 15'd3200, 1'b1},
      '{CMD_MOUSE, 16'sd0, 16'sd0, 12'd1, 12'd1, 4'd0, 15'd0, 15'd0, 1'b0},
      '{CMD_MOVE, -16'sd5, -16'sd5, 12'd1, 12'd1, 4'd3, 15'd0, 15'd0, 1'b0},
      '{CMD_MOVE, 16'sd7, 16'sd7, 12'd1, 12'd1, 4'd15, 15'd0, 15'd0, 1'b0},
      '{CMD_MOVE, 16'sd7, 16'sd7, 12'd1, 12'd1, 4'd4, 15'd0, 15'd0, 1'b0}
   };
   typed_rsp dir_exp [] = '{
      '{1'b1, '{ST_OK, 4'd0, 1'b0, 4'd0, 12'd0, 12'd0}},
      '{1'b1, '{ST_BADH, 4'd0, 1'b0, 4'd0, 12'd0, 12'd0}},
      '{1'b1, '{ST_OK, 4'd0, 1'b0, 4'd0, 12'd0, 12'd0}},
      '{1'b1, '{ST_OK, 4'd0, 1'b1, 4'd0, 12'd0, 12'd0}},
      '{1'b1, '{ST_OK, 4'd1, 1'b1, 4'd1, 12'd0, 12'd0}},
      '{1'b1, '{ST_OK, 4'd2, 1'b1, 4'd2, 12'd0, 12'd0}},
      '{1'b1, '{ST_OK, 4'd0, 1'b1, 4'd2, 12'd1024, 12'd768}},
      '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0},
      '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0}, '{1'b0, '0},
      '{1'b0, '0}, '{1'b0, '0}
   };

   function automatic int topmost_hit(input int x, input int y);
      int l, t;
      for (int i = int'(win_count) - 1; i >= 0; i--) begin
         l = int'($signed(win_x[z_order[i]]));
         t = int'($signed(win_y[z_order[i]]));
         if (x >= l && x < l + int'(win_w[z_order[i]]) &&
             y >= t && y < t + int'(win_h[z_order[i]]))
            return i;
      end
      return -1;
   endfunction

   function automatic rsp_item predict_window_op(input req_item r);
      rsp_item o;
      int nx, ny, p;
      logic [3:0] s;
      o = '0;
      case (r.cmd)
         CMD_ADD: begin
            if (win_count >= N_WIN) begin
               o.st = ST_FULL;
            end else begin
               win_x[win_count] = r.px;
               win_y[win_count] = r.py;
               win_w[win_count] = r.w;
               win_h[win_count] = r.h;
               z_order[win_count] = 4'(win_count);
               o.nh = 4'(win_count);
               win_count++;
            end
         end
         CMD_MOUSE: begin
            nx = int'((scr_w * r.rx) / RAW_MAX);
            ny = int'((scr_h * r.ry) / RAW_MAX);
            if (r.lp && !was_left) begin
               p = topmost_hit(nx, ny);
               if (p >= 0) begin
                  s = z_order[p];
                  for (int i = p; i + 1 < int'(win_count); i++)
                     z_order[i] = z_order[i + 1];
                  z_order[win_count - 1] = s;
               end
            end
            if (r.lp) begin
               if (!dragging) begin
                  p = topmost_hit(nx, ny);
                  if (p >= 0) begin
                     dragging = 1'b1;
                     drag_slot = z_order[p];
                  end
               end
               if (dragging) begin
                  win_x[drag_slot] = 16'(int'(win_x[drag_slot]) + nx - int'(cur_x));
                  win_y[drag_slot] = 16'(int'(win_y[drag_slot]) + ny - int'(cur_y));
               end
            end else begin
               dragging = 1'b0;
               drag_slot = '0;
            end
            cur_x = nx & 12'hFFF;
            cur_y = ny & 12'hFFF;
            was_left = r.lp;
         end
         CMD_MOVE: begin
            if (r.hd >= win_count) begin
               o.st = ST_BADH;
            end else begin
               win_x[r.hd] = r.px;
               win_y[r.hd] = r.py;
            end
         end
         default: ;
      endcase
      o.tv = win_count != 0;
      o.th = win_count != 0 ? z_order[win_count - 1] : 4'd0;
      o.cx = 12'(cur_x);
      o.cy = 12'(cur_y);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_item e, a;
      rsp_item p;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) scr_w = csr_wdata;
            else scr_h = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            a = '{status_type'(rsp_status), rsp_new_handle, rsp_top_valid,
                  rsp_top_handle, rsp_cursor_x, rsp_cursor_y};
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with none expected: %p", $time, a);
               errors++;
            end else begin
               e = pending_rsp.pop_front();
               if (e.st != a.st) begin
                  $display("%0t: status exp %0d got %0d", $time, e.st, a.st);
                  errors++;
               end
               if (e.nh != a.nh) begin
                  $display("%0t: new_handle exp %0d got %0d", $time, e.nh, a.nh);
                  errors++;
               end
               if (e.tv != a.tv) begin
                  $display("%0t: top_valid exp %0d got %0d", $time, e.tv, a.tv);
                  errors++;
               end
               if (e.th != a.th) begin
                  $display("%0t: top_handle exp %0d got %0d", $time, e.th, a.th);
                  errors++;
               end
               if (e.cx != a.cx) begin
                  $display("%0t: cursor_x exp %0d got %0d", $time, e.cx, a.cx);
                  errors++;
               end
               if (e.cy != a.cy) begin
                  $display("%0t: cursor_y exp %0d got %0d", $time, e.cy, a.cy);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            p = predict_window_op('{cmd_type'(req_cmd), req_pos_x, req_pos_y, req_size_w,
                                   req_size_h, req_handle, req_raw_x, req_raw_y,
                                   req_left_pressed});
            if (n_acc < dir_exp.size() && dir_exp[n_acc].typed)
               p = dir_exp[n_acc].r;
            pending_rsp = {pending_rsp, p};
            n_acc++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_ready <= quiet || $urandom_range(0, 2) != 0;
            repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   int unsigned scr_cfg [5][2] = '{'{1024, 768}, '{4095, 4095}, '{1, 1},
                                   '{0, 0}, '{640, 480}};
   int     held_left = 0;
   logic [14:0] last_rx = '0, last_ry = '0;

   function automatic req_item random_request();
      req_item r;
      int      k;
      r = '{cmd_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 12'($urandom),
            12'($urandom), 4'($urandom), 15'($urandom), 15'($urandom), 1'($urandom)};
      if (r.w == 0) r.w = 1;
      if (r.h == 0) r.h = 1;
      k = $urandom_range(0, 99);
      if (k < 8) begin
         r.cmd = CMD_ADD;
         if ($urandom_range(0, 3) != 0) begin
            r.px = 16'($urandom_range(0, 900));
            r.py = 16'($urandom_range(0, 700));
            r.w = 12'($urandom_range(1, 600));
            r.h = 12'($urandom_range(1, 600));
         end
      end else if (k < 18) begin
         r.cmd = CMD_MOVE;
         if ($urandom_range(0, 1)) begin
            r.px = 16'($urandom_range(0, 900));
            r.py = 16'($urandom_range(0, 700));
         end
      end else if (k < 21) begin
         r.cmd = CMD_NONE;
      end else begin
         r.cmd = CMD_MOUSE;
         if (held_left > 0) begin
            held_left--;
            r.rx = 15'(last_rx + $urandom_range(0, 4000) - 2000);
            r.ry = 15'(last_ry + $urandom_range(0, 4000) - 2000);
            r.lp = held_left != 0 || $urandom_range(0, 9) == 0;
         end else if (k < 80) begin
            held_left = $urandom_range(1, 8);
            r.lp = 1'b1;
         end
         if ($urandom_range(0, 19) == 0) r.rx = $urandom_range(0, 1) ? 15'h7FFF : 15'h0;
         last_rx = r.rx;
         last_ry = r.ry;
      end
      return r;
   endfunction

   initial begin
      req_item r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < dir_req.size(); i++) begin
         r = dir_req[i];
         req_valid <= 1'b1;
         {req_cmd, req_pos_x, req_pos_y, req_size_w, req_size_h, req_handle,
          req_raw_x, req_raw_y, req_left_pressed} <= r;
         do @(posedge clock); while (!req_ready);
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      for (int ph = 0; ph < 5; ph++) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (8) @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= CSR_WIDTH;
         csr_wdata <= 12'(scr_cfg[ph][0]);
         @(posedge clock);
         csr_index <= CSR_HEIGHT;
         csr_wdata <= 12'(scr_cfg[ph][1]);
         @(posedge clock);
         csr_we <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            quiet = ph == 4 && n >= PHASE_ITEMS - 100;
            if (ph == 1 && n == 40) long_hold = 1'b1;
            if (ph == 2 && n == 60) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_rsp.size() != 0) @(posedge clock);
            end
            r = random_request();
            req_valid <= 1'b1;
            {req_cmd, req_pos_x, req_pos_y, req_size_w, req_size_h, req_handle,
             req_raw_x, req_raw_y, req_left_pressed} <= r;
            do @(posedge clock); while (!req_ready);
            if (!quiet && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
